FILE: sv/h4d_pkg.sv
`timescale 1ns / 1ps
// h4d_pkg: shared types and codes for the h4 hci receive deframer
// holds the parser phase, result kinds, packet type bytes and state/result structs
// no dependencies
package h4d_pkg;

    typedef enum logic [1:0] {
        PH_TYPE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    localparam logic [2:0] KIND_START   = 3'd0;
    localparam logic [2:0] KIND_BYTE    = 3'd1;
    localparam logic [2:0] KIND_SLEEP   = 3'd2;
    localparam logic [2:0] KIND_BADTYPE = 3'd3;
    localparam logic [2:0] KIND_ABORT   = 3'd4;

    localparam logic [7:0] TYPE_ACL    = 8'h02;
    localparam logic [7:0] TYPE_EVENT  = 8'h04;
    localparam logic [5:0] SLEEP_UPPER = 6'b001100;

    localparam logic [1:0] ACL_HDR_LAST = 2'd3;
    localparam logic [1:0] ACL_LEN_LO   = 2'd2;

    localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

    typedef struct packed {
        phase_t      phase;
        logic        is_event;
        logic [1:0]  hdr_idx;
        logic [7:0]  len_lo;
        logic [15:0] left;
        logic [15:0] pkt_len;
    } parse_state_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic        is_event;
        logic        in_header;
        logic        last;
        logic [1:0]  sleep_code;
        logic [15:0] payload_len;
    } parse_result_t;

endpackage

FILE: sv/h4d_step.sv
`timescale 1ns / 1ps
// h4d_step: per-byte parser step, next state and result for one received byte
// depends on h4d_pkg
module h4d_step (
    input  h4d_pkg::parse_state_t  cur,
    input  logic [7:0]             rx_byte,
    input  logic [15:0]            max_len,
    output h4d_pkg::parse_state_t  nxt,
    output h4d_pkg::parse_result_t res
);
    import h4d_pkg::*;

    logic        hdr_last;
    logic [15:0] hdr_len_val;
    logic        fin;

    always_comb
    begin
        hdr_last    = cur.is_event ? (cur.hdr_idx != 2'd0) : (cur.hdr_idx == ACL_HDR_LAST);
        hdr_len_val = cur.is_event ? {8'h00, rx_byte} : {rx_byte, cur.len_lo};
        fin         = (cur.left <= 16'd1);

        nxt = cur;
        res = '0;
        res.data_byte = rx_byte;

        unique case (cur.phase)
            PH_HEADER:
            begin
                res.kind      = KIND_BYTE;
                res.is_event  = cur.is_event;
                res.in_header = 1'b1;
                if (!hdr_last)
                begin
                    if (!cur.is_event && cur.hdr_idx == ACL_LEN_LO)
                    begin
                        nxt.len_lo = rx_byte;
                    end
                    nxt.hdr_idx = cur.hdr_idx + 2'd1;
                end
                else
                begin
                    nxt.pkt_len = hdr_len_val;
                    nxt.hdr_idx = 2'd0;
                    if (hdr_len_val > max_len)
                    begin
                        nxt.phase       = PH_TYPE;
                        nxt.left        = '0;
                        res.kind        = KIND_ABORT;
                        res.last        = 1'b1;
                        res.payload_len = hdr_len_val;
                    end
                    else if (hdr_len_val == 16'd0)
                    begin
                        nxt.phase = PH_TYPE;
                        nxt.left  = '0;
                        res.last  = 1'b1;
                    end
                    else
                    begin
                        nxt.phase       = PH_PAYLOAD;
                        nxt.left        = hdr_len_val;
                        res.payload_len = hdr_len_val;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                nxt.left = fin ? 16'd0 : cur.left - 16'd1;
                if (fin)
                begin
                    nxt.phase = PH_TYPE;
                end
                res.kind        = KIND_BYTE;
                res.is_event    = cur.is_event;
                res.last        = fin;
                res.payload_len = cur.pkt_len;
            end
            default:
            begin
                nxt.phase   = PH_TYPE;
                nxt.hdr_idx = 2'd0;
                nxt.left    = '0;
                nxt.pkt_len = '0;
                if (rx_byte == TYPE_ACL || rx_byte == TYPE_EVENT)
                begin
                    nxt.is_event = (rx_byte == TYPE_EVENT);
                    nxt.phase    = PH_HEADER;
                    res.kind     = KIND_START;
                    res.is_event = (rx_byte == TYPE_EVENT);
                end
                else if (rx_byte[7:2] == SLEEP_UPPER)
                begin
                    res.kind       = KIND_SLEEP;
                    res.sleep_code = rx_byte[1:0];
                end
                else
                begin
                    res.kind = KIND_BADTYPE;
                end
            end
        endcase
    end

endmodule

FILE: sv/h4_hci_receive_deframer.sv
`timescale 1ns / 1ps
// h4_hci_receive_deframer: top level of the h4 uart receive deframer
// depends on h4d_pkg and h4d_step
//
// usage:
//   rx channel (rx_valid/rx_stall/rx_byte) takes one uart byte per request
//   res channel (res_valid/res_stall + result fields) gives exactly one
//   result per received byte: start, packet byte, sleep command, bad type
//   or length abort, with header/last flags and the decoded length
//   max_len_we/max_len_wdata set the largest accepted payload length
//   (reset 1024); write it only while no byte is in flight
// timing:
//   a byte is captured in an input register, parsed in one pass of short
//   logic, and lands in the result register, which drives res_valid; one
//   byte per cycle sustained while res_stall does not hold the result, as
//   the parser state updates with each parsed byte
// reset: both stages empty, parser waits for a type byte
// stall: a held result holds the parse stage, which then stalls rx; no
//   byte is dropped or repeated
module h4_hci_receive_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [2:0]  kind,
    output logic [7:0]  data_byte,
    output logic        packet_is_event,
    output logic        in_header,
    output logic        last,
    output logic [1:0]  sleep_code,
    output logic [15:0] payload_len,
    input  logic        max_len_we,
    input  logic [15:0] max_len_wdata
);
    import h4d_pkg::*;

    logic          in_full_reg;
    logic [7:0]    in_byte_reg;
    logic          out_full_reg;
    parse_result_t out_reg;
    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t res_next;
    logic [15:0]   max_len_reg;
    logic          out_hold;
    logic          advance;

    assign out_hold = out_full_reg && res_stall;
    assign advance  = in_full_reg && !out_hold;
    assign rx_stall = in_full_reg && out_hold;

    h4d_step u_step (
        .cur     (state_reg),
        .rx_byte (in_byte_reg),
        .max_len (max_len_reg),
        .nxt     (state_next),
        .res     (res_next)
    );

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (!rx_stall)
        begin
            in_full_reg <= rx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && !rx_stall)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // parser state and config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= '{phase: PH_TYPE, default: '0};
            max_len_reg <= MAX_LEN_RESET;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (max_len_we)
            begin
                max_len_reg <= max_len_wdata;
            end
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
        end
        else if (!out_hold)
        begin
            out_full_reg <= in_full_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= res_next;
        end
    end

    assign res_valid       = out_full_reg;
    assign kind            = out_reg.kind;
    assign data_byte       = out_reg.data_byte;
    assign packet_is_event = out_reg.is_event;
    assign in_header       = out_reg.in_header;
    assign last            = out_reg.last;
    assign sleep_code      = out_reg.sleep_code;
    assign payload_len     = out_reg.payload_len;

endmodule

FILE: tb/sv/h4_hci_receive_deframer_test.sv
`timescale 1ns / 1ps
// h4_hci_receive_deframer_test: self-checking bench for the h4 hci receive deframer
// drives acl/event packets, sleep commands, bad types and noise with random gaps and
// result stalls, predicts every result in-bench; depends on h4d_pkg and the deframer
module h4_hci_receive_deframer_test;
    import h4d_pkg::*;

    localparam logic [1:0] EVT_HDR_LAST = 2'd1;
    localparam logic [7:0] SLEEP_BASE   = 8'h30;
    localparam logic [7:0] SLEEP_TOP    = 8'h33;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        rx_valid = 1'b0;
    logic        rx_stall;
    logic [7:0]  rx_byte = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic        packet_is_event;
    logic        in_header;
    logic        last;
    logic [1:0]  sleep_code;
    logic [15:0] payload_len;
    logic        max_len_we = 1'b0;
    logic [15:0] max_len_wdata = '0;

    h4_hci_receive_deframer uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx_valid        (rx_valid),
        .rx_stall        (rx_stall),
        .rx_byte         (rx_byte),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .kind            (kind),
        .data_byte       (data_byte),
        .packet_is_event (packet_is_event),
        .in_header       (in_header),
        .last            (last),
        .sleep_code      (sleep_code),
        .payload_len     (payload_len),
        .max_len_we      (max_len_we),
        .max_len_wdata   (max_len_wdata)
    );

    // deframer prediction state
    phase_t      frm_phase;
    logic        frm_event;
    logic [1:0]  frm_hdr_idx;
    logic [7:0]  frm_len_lo;
    logic [15:0] frm_left;
    logic [15:0] frm_pkt_len;
    logic [15:0] max_limit;

    logic [7:0]    pending_bytes[$];
    parse_result_t expected_results[$];
    parse_result_t new_result;
    parse_result_t want;
    int            pushed_count = 0;
    int            fail_count = 0;
    int            gap_left;
    int            stall_left;
    logic          calm = 1'b0;

    always #5 clk = ~clk;

    task automatic deframer_clear();
        frm_phase   = PH_TYPE;
        frm_event   = 1'b0;
        frm_hdr_idx = '0;
        frm_len_lo  = '0;
        frm_left    = '0;
        frm_pkt_len = '0;
        max_limit   = MAX_LEN_RESET;
    endtask

    task automatic deframe_byte(input logic [7:0] b, output parse_result_t r);
        logic hdr_done;
        r = '0;
        r.data_byte = b;
        case (frm_phase)
            PH_HEADER:
            begin
                r.is_event  = frm_event;
                r.in_header = 1'b1;
                r.kind      = KIND_BYTE;
                hdr_done = frm_event ? (frm_hdr_idx == EVT_HDR_LAST)
                                     : (frm_hdr_idx == ACL_HDR_LAST);
                if (!hdr_done)
                begin
                    if (!frm_event && frm_hdr_idx == ACL_LEN_LO)
                        frm_len_lo = b;
                    frm_hdr_idx = frm_hdr_idx + 2'd1;
                end
                else
                begin
                    frm_pkt_len = frm_event ? {8'h00, b} : {b, frm_len_lo};
                    frm_hdr_idx = '0;
                    r.payload_len = frm_pkt_len;
                    if (frm_pkt_len > max_limit)
                    begin
                        frm_phase = PH_TYPE;
                        frm_left  = '0;
                        r.kind    = KIND_ABORT;
                        r.last    = 1'b1;
                    end
                    else if (frm_pkt_len == 16'd0)
                    begin
                        frm_phase = PH_TYPE;
                        frm_left  = '0;
                        r.last    = 1'b1;
                    end
                    else
                    begin
                        frm_phase = PH_PAYLOAD;
                        frm_left  = frm_pkt_len;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                r.kind        = KIND_BYTE;
                r.is_event    = frm_event;
                r.payload_len = frm_pkt_len;
                if (frm_left <= 16'd1)
                begin
                    frm_left  = '0;
                    frm_phase = PH_TYPE;
                    r.last    = 1'b1;
                end
                else
                    frm_left = frm_left - 16'd1;
            end
            default:
            begin
                frm_phase   = PH_TYPE;
                frm_hdr_idx = '0;
                frm_left    = '0;
                frm_pkt_len = '0;
                if (b == TYPE_ACL || b == TYPE_EVENT)
                begin
                    frm_event  = (b == TYPE_EVENT);
                    frm_phase  = PH_HEADER;
                    r.kind     = KIND_START;
                    r.is_event = frm_event;
                end
                else if (b >= SLEEP_BASE && b <= SLEEP_TOP)
                begin
                    r.kind       = KIND_SLEEP;
                    r.sleep_code = b[1:0];
                end
                else
                    r.kind = KIND_BADTYPE;
            end
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // rx side: feeds pending bytes, predicts each accepted request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_valid <= 1'b0;
            rx_byte  <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (rx_valid && !rx_stall)
            begin
                deframe_byte(rx_byte, new_result);
                expected_results.push_back(new_result);
            end
            if (!rx_valid || !rx_stall)
            begin
                if (gap_left != 0)
                begin
                    rx_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_bytes.size() != 0)
                begin
                    rx_valid <= 1'b1;
                    rx_byte  <= pending_bytes.pop_front();
                    gap_left <= pick_gap();
                end
                else
                    rx_valid <= 1'b0;
            end
        end
    end

    // result side stall bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            res_stall  <= (stall_left != 0);
            stall_left <= (stall_left != 0) ? stall_left - 1 : pick_stall();
        end
    end

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0h byte %0h",
                         $time, kind, data_byte);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(kind));
                check_field("data_byte", 32'(want.data_byte), 32'(data_byte));
                check_field("packet_is_event", 32'(want.is_event), 32'(packet_is_event));
                check_field("in_header", 32'(want.in_header), 32'(in_header));
                check_field("last", 32'(want.last), 32'(last));
                check_field("sleep_code", 32'(want.sleep_code), 32'(sleep_code));
                check_field("payload_len", 32'(want.payload_len), 32'(payload_len));
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        pushed_count++;
    endtask

    task automatic queue_frame(input logic is_evt, input int len);
        logic [15:0] l16;
        l16 = len[15:0];
        if (is_evt)
        begin
            push_byte(TYPE_EVENT);
            push_byte(8'($urandom));
            push_byte(l16[7:0]);
        end
        else
        begin
            push_byte(TYPE_ACL);
            push_byte(8'($urandom));
            push_byte(8'($urandom));
            push_byte(l16[7:0]);
            push_byte(l16[15:8]);
        end
        if (l16 <= max_limit)
            repeat (l16) push_byte(8'($urandom));
    endtask

    function automatic int pick_len(input logic is_evt);
        int top;
        int sel;
        int len;
        top = is_evt ? 255 : 65535;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            len = $urandom_range(0, 12);
        else if (sel < 8)
            len = int'(max_limit) + $urandom_range(0, 2) - 1;
        else if (sel < 9)
            len = $urandom_range(0, top);
        else
            len = 0;
        if (len < 0)
            len = 0;
        if (len > top)
            len = top;
        if (len <= int'(max_limit) && len > 40)
            len = $urandom_range(13, 40);
        return len;
    endfunction

    task automatic random_phase(input int budget);
        int start;
        int r;
        logic [7:0] b;
        logic is_evt;
        start = pushed_count;
        while (pushed_count - start < budget)
        begin
            r = $urandom_range(0, 99);
            is_evt = 1'($urandom_range(0, 1));
            if (r < 70)
                queue_frame(is_evt, pick_len(is_evt));
            else if (r < 78)
                push_byte(SLEEP_BASE + 8'($urandom_range(0, 3)));
            else if (r < 86)
            begin
                do
                    b = 8'($urandom);
                while (b == TYPE_ACL || b == TYPE_EVENT || (b >= SLEEP_BASE && b <= SLEEP_TOP));
                push_byte(b);
            end
            else if (r < 94)
            begin
                // type byte with at most two header bytes: cuts an acl header short, an event header may complete
                push_byte(is_evt ? TYPE_EVENT : TYPE_ACL);
                repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
            end
            else
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_bytes.size() != 0 || rx_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_max(input logic [15:0] v);
        wait_idle();
        @(posedge clk);
        max_len_we    <= 1'b1;
        max_len_wdata <= v;
        @(posedge clk);
        max_len_we <= 1'b0;
        max_limit = v;
        @(negedge clk);
    endtask

    initial
    begin
        deframer_clear();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h30);
        push_byte(8'h31);
        push_byte(8'h32);
        push_byte(8'h33);
        push_byte(8'h2F);
        push_byte(8'h34);
        queue_frame(1'b1, 0);
        queue_frame(1'b0, 0);
        queue_frame(1'b1, 1);
        queue_frame(1'b0, 16'hFFFF);
        wait_idle();

        queue_frame(1'b0, 300);
        random_phase(130);
        set_max(16'd0);
        random_phase(80);
        set_max(16'hFFFF);
        queue_frame(1'b1, 255);
        random_phase(120);
        set_max(16'($urandom_range(1, 40)));
        random_phase(100);
        set_max(16'd256);
        calm = 1'b1;
        random_phase(100);
        wait_idle();
        calm = 1'b0;
        set_max(16'd1024);
        random_phase(120);

        wait_idle();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
